// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file cmst_checker.sv.
// Needs signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is high.
`define CMST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every rising clock edge, reset included.
`define CMST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== hw/rtl/cmst_pkg.sv =====
// Shared types, constants and command/status structs of the sketch unit.
// No dependencies; imported by every module of the block.
package cmst_pkg;

   // Sketch geometry
   localparam int MAX_WIDTH  = 4096;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int MAX_ROWS   = 8;
   localparam int ROW_BITS   = $clog2(MAX_ROWS);
   localparam int CELLS      = MAX_ROWS * MAX_WIDTH;
   localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
   localparam int MAX_TOPN   = 32;
   localparam int TOPN_BITS  = $clog2(MAX_TOPN);
   localparam int IDX_BITS   = TOPN_BITS + 1;
   localparam int COUNT_BITS = 32;
   localparam int KEY_BITS   = 64;
   localparam int HASH_BITS  = 64;

   // Modulo unit: radix-16, one hash nibble per cycle
   localparam int MOD_RADIX_BITS = 4;
   localparam int MOD_STEPS      = HASH_BITS / MOD_RADIX_BITS;
   localparam int MOD_CNT_BITS   = $clog2(MOD_STEPS);

   // Configuration registers
   localparam int WIDTH_REG_BITS = 13;
   localparam int ROWS_REG_BITS  = 4;
   localparam int CAP_REG_BITS   = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOPN_CAP  = 2'd2;

   localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 13'd2719;
   localparam logic [ROWS_REG_BITS-1:0]  ROWS_RESET  = 4'd5;
   localparam logic [CAP_REG_BITS-1:0]   CAP_RESET   = 6'd10;

   // Function codes
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_LIST  = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   typedef logic [COUNT_BITS-1:0] cmst_count_type;
   localparam cmst_count_type COUNT_MAX = '1;

   typedef struct packed {
      logic [1:0]           func;
      logic [KEY_BITS-1:0]  item_key;
      logic [HASH_BITS-1:0] hash_base;
      logic [HASH_BITS-1:0] hash_step;
   } cmst_req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] result_key;
      cmst_count_type      estimate;
      logic                entry_valid;
      logic                held_in_topn;
      logic                last;
   } cmst_rsp_type;

   // One held top-n entry
   typedef struct packed {
      logic [KEY_BITS-1:0]  item_key;
      logic [HASH_BITS-1:0] hash_base;
      logic [HASH_BITS-1:0] hash_step;
   } cmst_entry_type;

   // One entry of the list work area
   typedef struct packed {
      logic [KEY_BITS-1:0] item_key;
      cmst_count_type      freq;
   } cmst_list_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_EST_INIT, ST_MOD_LOAD, ST_MOD_RUN, ST_CNT_RD,
      ST_CNT_WAIT, ST_UPD_INIT, ST_UPD, ST_HS_INIT, ST_HS_RD, ST_HS_CMP,
      ST_DECIDE, ST_REEST_RD, ST_REEST_LD, ST_REEST_TAKE, ST_CHOOSE,
      ST_CHECK, ST_WRITE, ST_OUT, ST_EMPTY, ST_FILL_INIT, ST_FILL_RD,
      ST_FILL_LD, ST_FILL_PUT, ST_SORT_INIT, ST_SORT_RD, ST_SORT_LD,
      ST_SCAN_RD, ST_SCAN_CMP, ST_EMIT
   } cmst_state_type;

   // What an estimate pass is done for
   typedef enum logic [1:0] {
      PH_REQ, PH_REEST, PH_LIST
   } cmst_phase_type;

   typedef struct packed {
      logic clr_step;
      logic req_load;
      logic est_init;
      logic est_src_heavy;
      logic mod_load;
      logic mod_step;
      logic cnt_read;
      logic cnt_accum;
      logic upd_init;
      logic upd_write;
      logic idx_clear;
      logic heavy_read;
      logic held_cmp;
      logic append_pick;
      logic reest_init;
      logic reest_take;
      logic choose;
      logic heavy_write;
      logic list_write;
      logic sort_init;
      logic sort_read;
      logic sort_load;
      logic scan_read;
      logic scan_cmp;
      logic emit;
      logic out_req;
      logic out_empty;
   } cmst_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic mod_last;
      logic row_last;
      logic idx_end;
      logic held;
      logic le_min;
      logic full;
      logic accept;
      logic j_end;
      logic i_last;
      logic count_zero;
      logic is_add;
   } cmst_stat_type;

endpackage

// ===== hw/rtl/cmst_dp.sv =====
// Datapath of the sketch unit: counter memory, modulo unit, top-n store,
// list work area, configuration and result registers. Uses cmst_pkg.
module cmst_dp import cmst_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmst_req_type              req_data,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  cmst_cmd_type              cmd,
   output cmst_stat_type             stat,
   output logic                      rsp_valid,
   output cmst_rsp_type              rsp_data
);

   // Configuration registers
   logic [WIDTH_REG_BITS-1:0] width_ff;
   logic [ROWS_REG_BITS-1:0]  rows_ff;
   logic [CAP_REG_BITS-1:0]   cap_ff;
   logic [WIDTH_REG_BITS-1:0] w_eff;
   logic [ROWS_REG_BITS-1:0]  rows_eff;
   logic [CAP_REG_BITS-1:0]   cap_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         rows_ff  <= ROWS_RESET;
         cap_ff   <= CAP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_WIDTH: width_ff <= csr_wdata[WIDTH_REG_BITS-1:0];
            CSR_ROW_COUNT: rows_ff  <= csr_wdata[ROWS_REG_BITS-1:0];
            CSR_TOPN_CAP:  cap_ff   <= csr_wdata[CAP_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp registers to their legal ranges
   always_comb begin
      if (width_ff == '0)                              w_eff = WIDTH_REG_BITS'(1);
      else if (width_ff > WIDTH_REG_BITS'(MAX_WIDTH))  w_eff = WIDTH_REG_BITS'(MAX_WIDTH);
      else                                             w_eff = width_ff;
      if (rows_ff == '0)                               rows_eff = ROWS_REG_BITS'(1);
      else if (rows_ff > ROWS_REG_BITS'(MAX_ROWS))     rows_eff = ROWS_REG_BITS'(MAX_ROWS);
      else                                             rows_eff = rows_ff;
      if (cap_ff == '0)                                cap_eff = CAP_REG_BITS'(1);
      else if (cap_ff > CAP_REG_BITS'(MAX_TOPN))       cap_eff = CAP_REG_BITS'(MAX_TOPN);
      else                                             cap_eff = cap_ff;
   end

   // Request register
   cmst_req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.req_load) req_ff <= req_data;
   end

   // Estimate pass registers
   logic [HASH_BITS-1:0]     hcur_ff;
   logic [HASH_BITS-1:0]     step_ff;
   logic [KEY_BITS-1:0]      ekey_ff;
   logic [ROW_BITS-1:0]      row_ff;
   cmst_count_type           est_ff;
   cmst_count_type           nf_ff;
   logic [COL_BITS-1:0]      cols_ff [MAX_ROWS];
   cmst_count_type           cvals_ff [MAX_ROWS];
   logic [HASH_BITS-1:0]     div_ff;
   logic [COL_BITS-1:0]      rem_ff;
   logic [MOD_CNT_BITS-1:0]  mcnt_ff;
   cmst_count_type           crd_ff;
   cmst_entry_type           hrd_ff;
   cmst_count_type           nf_calc;

   // Radix-16 restoring remainder step
   logic [HASH_BITS-1:0] mdiv;
   logic [COL_BITS-1:0]  mrem;
   always_comb begin
      logic [COL_BITS:0] t;
      mdiv = div_ff;
      mrem = rem_ff;
      t    = '0;
      for (int k = 0; k < MOD_RADIX_BITS; k++) begin
         t    = {mrem, mdiv[HASH_BITS-1]};
         mdiv = {mdiv[HASH_BITS-2:0], 1'b0};
         if (t >= (COL_BITS+1)'(w_eff)) t = t - (COL_BITS+1)'(w_eff);
         mrem = t[COL_BITS-1:0];
      end
   end

   assign nf_calc = (est_ff == COUNT_MAX) ? COUNT_MAX : est_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.est_init) begin
         hcur_ff <= cmd.est_src_heavy ? hrd_ff.hash_base : req_ff.hash_base;
         step_ff <= cmd.est_src_heavy ? hrd_ff.hash_step : req_ff.hash_step;
         ekey_ff <= hrd_ff.item_key;
         row_ff  <= '0;
         est_ff  <= COUNT_MAX;
      end
      if (cmd.mod_load) begin
         div_ff  <= hcur_ff;
         rem_ff  <= '0;
         mcnt_ff <= '0;
      end
      if (cmd.mod_step) begin
         div_ff  <= mdiv;
         rem_ff  <= mrem;
         mcnt_ff <= mcnt_ff + 1'b1;
      end
      // fold one row into the running minimum
      if (cmd.cnt_accum) begin
         if (crd_ff < est_ff) est_ff <= crd_ff;
         cols_ff[row_ff]  <= rem_ff;
         cvals_ff[row_ff] <= crd_ff;
         hcur_ff          <= hcur_ff + step_ff;
         row_ff           <= row_ff + 1'b1;
      end
      if (cmd.upd_init) begin
         row_ff <= '0;
         nf_ff  <= nf_calc;
      end
      if (cmd.upd_write) row_ff <= row_ff + 1'b1;
   end

   // Counter memory with clearing pass
   logic [COUNT_BITS-1:0] cnt_mem [CELLS];
   logic [ADDR_BITS-1:0]  clr_addr_ff;
   logic [ADDR_BITS-1:0]  cnt_waddr;
   cmst_count_type        cnt_wdata;
   logic                  cnt_we;

   always_ff @(posedge clock) begin
      if (reset)             clr_addr_ff <= '0;
      else if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + 1'b1;
   end

   always_comb begin
      cnt_we = cmd.clr_step | cmd.upd_write;
      if (cmd.clr_step) begin
         cnt_waddr = clr_addr_ff;
         cnt_wdata = '0;
      end else begin
         cnt_waddr = {row_ff, cols_ff[row_ff]};
         cnt_wdata = (nf_ff > cvals_ff[row_ff]) ? nf_ff : cvals_ff[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we)       cnt_mem[cnt_waddr] <= cnt_wdata;
      if (cmd.cnt_read) crd_ff <= cnt_mem[{row_ff, rem_ff}];
   end

   // Top-n list state
   logic [IDX_BITS-1:0]  count_ff;
   cmst_count_type       hmin_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic                 held_ff;
   logic [TOPN_BITS-1:0] slot_ff;
   cmst_count_type       newmin_ff;
   logic                 full;

   assign full = (count_ff >= IDX_BITS'(cap_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hmin_ff  <= '0;
      end else if (cmd.heavy_write) begin
         if ({1'b0, slot_ff} == count_ff) count_ff <= count_ff + 1'b1;
         hmin_ff <= newmin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_clear) begin
         idx_ff  <= '0;
         held_ff <= 1'b0;
      end
      if (cmd.held_cmp) begin
         if (hrd_ff.item_key == req_ff.item_key) held_ff <= 1'b1;
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.append_pick) begin
         slot_ff   <= count_ff[TOPN_BITS-1:0];
         newmin_ff <= nf_ff;
      end
      if (cmd.reest_init) begin
         newmin_ff <= COUNT_MAX;
         slot_ff   <= '0;
         idx_ff    <= '0;
      end
      // keep the first entry with the least re-estimate
      if (cmd.reest_take) begin
         if (est_ff < newmin_ff) begin
            newmin_ff <= est_ff;
            slot_ff   <= idx_ff[TOPN_BITS-1:0];
         end
         idx_ff <= idx_ff + 1'b1;
      end
      // room left: append instead of replace
      if (cmd.choose && !full) begin
         slot_ff <= count_ff[TOPN_BITS-1:0];
         if (nf_ff < newmin_ff) newmin_ff <= nf_ff;
      end
      if (cmd.heavy_write) held_ff <= 1'b1;
      if (cmd.list_write) idx_ff <= idx_ff + 1'b1;
   end

   // Top-n entry memory
   cmst_entry_type hv_mem [MAX_TOPN];
   always_ff @(posedge clock) begin
      if (cmd.heavy_write)
         hv_mem[slot_ff] <= '{req_ff.item_key, req_ff.hash_base, req_ff.hash_step};
      if (cmd.heavy_read) hrd_ff <= hv_mem[idx_ff[TOPN_BITS-1:0]];
   end

   // List work area and selection sort
   cmst_list_type        lst_mem [MAX_TOPN];
   cmst_list_type        lrd_ff;
   cmst_list_type        cur_ff;
   cmst_list_type        bent_ff;
   logic [IDX_BITS-1:0]  i_ff;
   logic [IDX_BITS-1:0]  j_ff;
   logic [TOPN_BITS-1:0] best_ff;
   logic                 i_last;

   assign i_last = (i_ff + 1'b1 == count_ff);

   always_ff @(posedge clock) begin
      if (cmd.list_write)
         lst_mem[idx_ff[TOPN_BITS-1:0]] <= '{ekey_ff, est_ff};
      if (cmd.emit) lst_mem[best_ff] <= cur_ff;
      if (cmd.sort_read)      lrd_ff <= lst_mem[i_ff[TOPN_BITS-1:0]];
      else if (cmd.scan_read) lrd_ff <= lst_mem[j_ff[TOPN_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_init) i_ff <= '0;
      if (cmd.sort_load) begin
         cur_ff  <= lrd_ff;
         bent_ff <= lrd_ff;
         best_ff <= i_ff[TOPN_BITS-1:0];
         j_ff    <= i_ff + 1'b1;
      end
      if (cmd.scan_cmp) begin
         if (lrd_ff.freq > bent_ff.freq) begin
            bent_ff <= lrd_ff;
            best_ff <= j_ff[TOPN_BITS-1:0];
         end
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.emit) i_ff <= i_ff + 1'b1;
   end

   // Result register
   logic         rsp_valid_ff;
   cmst_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.out_req | cmd.out_empty | cmd.emit;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_req) begin
         rsp_ff.result_key   <= req_ff.item_key;
         rsp_ff.estimate     <= (req_ff.func == FUNC_ADD) ? nf_ff : est_ff;
         rsp_ff.entry_valid  <= 1'b1;
         rsp_ff.held_in_topn <= held_ff;
         rsp_ff.last         <= 1'b1;
      end else if (cmd.out_empty) begin
         rsp_ff.result_key   <= '0;
         rsp_ff.estimate     <= '0;
         rsp_ff.entry_valid  <= 1'b0;
         rsp_ff.held_in_topn <= 1'b0;
         rsp_ff.last         <= 1'b1;
      end else if (cmd.emit) begin
         rsp_ff.result_key   <= bent_ff.item_key;
         rsp_ff.estimate     <= bent_ff.freq;
         rsp_ff.entry_valid  <= 1'b1;
         rsp_ff.held_in_topn <= 1'b1;
         rsp_ff.last         <= i_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to the controller
   always_comb begin
      stat.clr_done   = &clr_addr_ff;
      stat.mod_last   = (mcnt_ff == MOD_CNT_BITS'(MOD_STEPS - 1));
      stat.row_last   = ({1'b0, row_ff} == rows_eff - 1'b1);
      stat.idx_end    = (idx_ff == count_ff);
      stat.held       = held_ff;
      stat.le_min     = (nf_ff <= hmin_ff);
      stat.full       = full;
      stat.accept     = (newmin_ff <= nf_ff);
      stat.j_end      = (j_ff == count_ff);
      stat.i_last     = i_last;
      stat.count_zero = (count_ff == '0);
      stat.is_add     = (req_ff.func == FUNC_ADD);
   end

endmodule

// ===== hw/rtl/cmst_ctrl.sv =====
// Controller state machine of the sketch unit: sequences the datapath
// through estimate, update, top-n offer and list passes. Uses cmst_pkg.
module cmst_ctrl import cmst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_func,
   input  cmst_stat_type stat,
   output cmst_cmd_type  cmd,
   output logic          busy
);

   cmst_state_type state_ff, state_in;
   cmst_phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         phase_ff <= PH_REQ;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         ST_CLEAR:    if (stat.clr_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               phase_in = PH_REQ;
               unique case (req_func)
                  FUNC_ADD, FUNC_QUERY: state_in = ST_EST_INIT;
                  FUNC_LIST: state_in = ST_EMPTY;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_EST_INIT: state_in = ST_MOD_LOAD;
         ST_MOD_LOAD: state_in = ST_MOD_RUN;
         ST_MOD_RUN:  if (stat.mod_last) state_in = ST_CNT_RD;
         ST_CNT_RD:   state_in = ST_CNT_WAIT;
         ST_CNT_WAIT: begin
            if (!stat.row_last) state_in = ST_MOD_LOAD;
            else begin
               unique case (phase_ff)
                  PH_REQ:   state_in = stat.is_add ? ST_UPD_INIT : ST_HS_INIT;
                  PH_REEST: state_in = ST_REEST_TAKE;
                  default:  state_in = ST_FILL_PUT;
               endcase
            end
         end
         ST_UPD_INIT: state_in = ST_UPD;
         ST_UPD:      if (stat.row_last) state_in = ST_HS_INIT;
         ST_HS_INIT:  state_in = ST_HS_RD;
         ST_HS_RD: begin
            if (!stat.idx_end) state_in = ST_HS_CMP;
            else if (stat.is_add && !stat.held) state_in = ST_DECIDE;
            else state_in = ST_OUT;
         end
         ST_HS_CMP:   state_in = ST_HS_RD;
         ST_DECIDE: begin
            if (stat.le_min) state_in = stat.full ? ST_OUT : ST_WRITE;
            else begin
               state_in = ST_REEST_RD;
               phase_in = PH_REEST;
            end
         end
         ST_REEST_RD:   state_in = stat.idx_end ? ST_CHOOSE : ST_REEST_LD;
         ST_REEST_LD:   state_in = ST_MOD_LOAD;
         ST_REEST_TAKE: state_in = ST_REEST_RD;
         ST_CHOOSE:     state_in = ST_CHECK;
         ST_CHECK:      state_in = stat.accept ? ST_WRITE : ST_OUT;
         ST_WRITE:      state_in = ST_OUT;
         ST_OUT:        state_in = ST_IDLE;
         // list entry point: empty list answers at once
         ST_EMPTY: begin
            if (stat.count_zero) state_in = ST_IDLE;
            else begin
               state_in = ST_FILL_INIT;
               phase_in = PH_LIST;
            end
         end
         ST_FILL_INIT:  state_in = ST_FILL_RD;
         ST_FILL_RD:    state_in = stat.idx_end ? ST_SORT_INIT : ST_FILL_LD;
         ST_FILL_LD:    state_in = ST_MOD_LOAD;
         ST_FILL_PUT:   state_in = ST_FILL_RD;
         ST_SORT_INIT:  state_in = ST_SORT_RD;
         ST_SORT_RD:    state_in = ST_SORT_LD;
         ST_SORT_LD:    state_in = ST_SCAN_RD;
         ST_SCAN_RD:    state_in = stat.j_end ? ST_EMIT : ST_SCAN_CMP;
         ST_SCAN_CMP:   state_in = ST_SCAN_RD;
         ST_EMIT:       state_in = stat.i_last ? ST_IDLE : ST_SORT_RD;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR:      cmd.clr_step = 1'b1;
         ST_IDLE:       cmd.req_load = start;
         ST_EST_INIT:   cmd.est_init = 1'b1;
         ST_MOD_LOAD:   cmd.mod_load = 1'b1;
         ST_MOD_RUN:    cmd.mod_step = 1'b1;
         ST_CNT_RD:     cmd.cnt_read = 1'b1;
         ST_CNT_WAIT:   cmd.cnt_accum = 1'b1;
         ST_UPD_INIT:   cmd.upd_init = 1'b1;
         ST_UPD:        cmd.upd_write = 1'b1;
         ST_HS_INIT:    cmd.idx_clear = 1'b1;
         ST_HS_RD:      cmd.heavy_read = !stat.idx_end;
         ST_HS_CMP:     cmd.held_cmp = 1'b1;
         ST_DECIDE: begin
            cmd.append_pick = stat.le_min && !stat.full;
            cmd.reest_init  = !stat.le_min;
         end
         ST_REEST_RD:   cmd.heavy_read = !stat.idx_end;
         ST_REEST_LD: begin
            cmd.est_init      = 1'b1;
            cmd.est_src_heavy = 1'b1;
         end
         ST_REEST_TAKE: cmd.reest_take = 1'b1;
         ST_CHOOSE:     cmd.choose = 1'b1;
         ST_CHECK:      ;
         ST_WRITE:      cmd.heavy_write = 1'b1;
         ST_OUT:        cmd.out_req = 1'b1;
         ST_EMPTY:      cmd.out_empty = stat.count_zero;
         ST_FILL_INIT:  cmd.idx_clear = 1'b1;
         ST_FILL_RD:    cmd.heavy_read = !stat.idx_end;
         ST_FILL_LD: begin
            cmd.est_init      = 1'b1;
            cmd.est_src_heavy = 1'b1;
         end
         ST_FILL_PUT:   cmd.list_write = 1'b1;
         ST_SORT_INIT:  cmd.sort_init = 1'b1;
         ST_SORT_RD:    cmd.sort_read = 1'b1;
         ST_SORT_LD:    cmd.sort_load = 1'b1;
         ST_SCAN_RD:    cmd.scan_read = !stat.j_end;
         ST_SCAN_CMP:   cmd.scan_cmp = 1'b1;
         ST_EMIT:       cmd.emit = 1'b1;
         default:       ;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hw/rtl/count_min_sketch_topn_unit.sv =====
// Top level of the count-min sketch with top-n heavy item list.
// Instantiates cmst_ctrl and cmst_dp; uses cmst_pkg.
//
// A transaction is taken when start is high and busy is low; each result
// shows on rsp_data for exactly one cycle with rsp_valid high and cannot be
// held off. After reset a clearing pass zeroes all 32768 counters, one per
// cycle, with busy high until it ends. Items are handled one at a time.
// The column of each row comes from a radix-16 modulo unit. A query
// estimates the item over the configured rows and scans the held entries;
// an add also updates the counter of each row and, when the item is not
// held and its new count exceeds the top-n minimum, re-estimates every
// held entry; a list re-estimates every held entry, selection sorts them
// and emits one result per held entry (one for an empty list). Function
// code 3 is taken and produces nothing. Configuration writes are always
// accepted and must come only while busy is low and no result is pending.
module count_min_sketch_topn_unit import cmst_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  cmst_req_type              req_data,
   output logic                      rsp_valid,
   output cmst_rsp_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cmst_cmd_type  cmd;
   cmst_stat_type stat;

   assign csr_ready = 1'b1;

   cmst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   cmst_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/cmst_checker.sv =====
// Port-level checker of the sketch unit, bound to the top level.
// Uses cmst_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module cmst_checker import cmst_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input cmst_req_type req_data,
   input logic         rsp_valid,
   input cmst_rsp_type rsp_data
);

   logic take_real;
   logic empty_ok;

   assign take_real = start && !busy && (req_data.func != FUNC_NONE);
   assign empty_ok  = rsp_data.last && !rsp_data.held_in_topn && (rsp_data.estimate == '0);

   // Counter clearing holds off transactions right after reset
   `CMST_ASSERT_ALWAYS(a_clear_after_reset, $past(reset) |-> busy, "not busy after reset")

   // A real function keeps the unit busy in the next cycle
   `CMST_ASSERT(a_busy_on_take, take_real |=> busy, "idle after take")

   // Nothing follows the final result of a transaction at once
   `CMST_ASSERT(a_gap_after_last, rsp_valid && rsp_data.last |=> !rsp_valid, "result after last")

   // An empty-list answer is all zero and final
   `CMST_ASSERT(a_empty_shape, rsp_valid && !rsp_data.entry_valid |-> empty_ok, "bad empty result")

endmodule

bind count_min_sketch_topn_unit cmst_checker u_cmst_checker (.*);
